// ===== design/mmhq_pkg.sv =====
package mmhq_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_REM_MIN = 2'd1,
    CMD_REM_MAX = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INS_RD,     // read parent
    S_INS_CMP,
    S_INS_GRD,    // read grandparent
    S_INS_GCMP,
    S_RMX_RD1,
    S_RMX_RD2,
    S_RMX_SEL,
    S_REM_RDV,    // read removed value
    S_REM_RDL,    // read last entry
    S_REM_PUT,
    S_TD_RDI,     // read node under trickle
    S_TD_SCAN,    // issue first candidate read
    S_TD_CMP,     // compare a candidate, read next
    S_TD_SWAP,
    S_TD_RDP,
    S_TD_PCMP,
    S_OUT
  } state_t;

  // Signed compare on raw words.
  function automatic logic lt32(input logic [31:0] a, input logic [31:0] b);
    lt32 = $signed(a) < $signed(b);
  endfunction

endpackage

// ===== design/min_max_heap_queue_core.sv =====
// Min-max heap priority queue core.
// Input channel in_*: tdata = {value[31:0], cmd[1:0]} in bits [1:0] and [33:2],
// zero padded to 40 bits. One request is taken only while the core is idle.
// Result channel out_*: tdata = status [1:0], removed_value [33:2],
// entry_count [41:34], zero padded to 48 bits. Exactly one result per request.
// Insert walks over the parent then one grandparent per step; removal
// trickles the last entry down over children and grandchildren, reading the
// up to six candidates from the heap memory one per cycle through its one
// read port, with one shared comparator doing every compare.
// A status-only request or an insert into an empty heap goes straight to S_OUT,
// where the result is registered; other requests walk the heap first. The core
// is ready again in the same cycle that the registered result appears.
// The result is held in an output register until taken; a stalled receiver
// holds the core in S_OUT with the next result, so no further request is taken.
// Reset clears the entry count and control; memory contents are not cleared
// since entries above the count are never read.
module min_max_heap_queue_core
  import mmhq_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cmd, value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status, removed_value, entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 3;   // wide enough for 4*i+6

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [XW-1:0] i_r, i_nxt, m_r, m_nxt, j_r, j_nxt;
  logic [31:0]   vi_r, vi_nxt, vm_r, vm_nxt, vtmp_r, vtmp_nxt;
  logic          mn_r, mn_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [1:0]    cmd_r, cmd_nxt;
  logic          rdvalid_r;
  logic [XW-1:0] rdidx_r;
  logic [47:0]   out_r, out_nxt;
  logic          ovalid_r, ovalid_nxt;

  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rdata_r;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata;
  logic          re;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  // Shared comparator: is cand better than inc on the level kind cmp_min.
  logic [31:0] cand, inc;
  logic        cmp_min;
  logic        better;

  always_comb begin
    cmp_min = mn_r;
    cand = rdata_r;
    inc = vi_r;
    case (state_r)
      S_INS_GCMP: begin
        cand = vi_r; inc = rdata_r;
      end
      S_RMX_SEL: begin
        cmp_min = 1'b1; cand = vtmp_r; inc = rdata_r;
      end
      S_TD_CMP: begin
        cand = rdata_r; inc = vm_r;
      end
      S_TD_SWAP: begin
        cand = vm_r; inc = vi_r;
      end
      default: begin
        cand = rdata_r; inc = vi_r;
      end
    endcase
  end

  assign better = lt32(cmp_min ? cand : inc, cmp_min ? inc : cand);

  function automatic logic min_level(input logic [XW-1:0] idx);
    logic [XW:0] v;
    logic        odd;
    v = {1'b0, idx} + 1'b1;
    odd = 1'b0;
    for (int k = 0; k <= XW; k++) begin
      if (v[k]) odd = k[0];
    end
    min_level = !odd;
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata = out_r;

  logic [XW-1:0] fc, fg;
  assign fc = {i_r[XW-2:0], 1'b1};
  assign fg = {i_r[XW-3:0], 2'b11};

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; i_nxt = i_r; m_nxt = m_r; j_nxt = j_r;
    vi_nxt = vi_r; vm_nxt = vm_r; vtmp_nxt = vtmp_r; mn_nxt = mn_r;
    status_nxt = status_r; rem_nxt = rem_r; cmd_nxt = cmd_r;
    out_nxt = out_r; ovalid_nxt = ovalid_r;
    we = 1'b0; waddr = '0; wdata = '0; re = 1'b0; raddr = '0;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt = in_tdata[1:0];
          status_nxt = ST_OK;
          rem_nxt = '0;
          case (cmd_t'(in_tdata[1:0]))
            CMD_INSERT: begin
              if (cnt_r >= CW'(CAPACITY)) begin
                status_nxt = ST_FULL;
                state_nxt = S_OUT;
              end else begin
                we = 1'b1; waddr = AW'(cnt_r); wdata = in_tdata[33:2];
                vi_nxt = in_tdata[33:2];
                i_nxt = XW'(cnt_r);
                mn_nxt = min_level(XW'(cnt_r));
                cnt_nxt = cnt_r + 1'b1;
                state_nxt = (cnt_r == '0) ? S_OUT : S_INS_RD;
              end
            end
            CMD_REM_MIN, CMD_REM_MAX: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt = S_OUT;
              end else if (in_tdata[1:0] == CMD_REM_MAX && cnt_r >= CW'(2)) begin
                i_nxt = XW'(1);
                state_nxt = S_RMX_RD1;
              end else begin
                i_nxt = '0;
                state_nxt = S_REM_RDV;
              end
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_INS_RD: begin
        re = 1'b1; raddr = AW'((i_r - 1'b1) >> 1);
        state_nxt = S_INS_CMP;
      end
      S_INS_CMP: begin
        // Parent is on the opposite level kind.
        if (better) begin
          we = 1'b1; waddr = AW'(i_r); wdata = rdata_r;
          i_nxt = (i_r - 1'b1) >> 1;
          mn_nxt = !mn_r;
        end
        state_nxt = S_INS_GRD;
      end
      S_INS_GRD: begin
        if (i_r >= XW'(3)) begin
          re = 1'b1; raddr = AW'((i_r - XW'(3)) >> 2);
          state_nxt = S_INS_GCMP;
        end else begin
          we = 1'b1; waddr = AW'(i_r); wdata = vi_r;
          state_nxt = S_OUT;
        end
      end
      S_INS_GCMP: begin
        if (better) begin
          we = 1'b1; waddr = AW'(i_r); wdata = rdata_r;
          i_nxt = (i_r - XW'(3)) >> 2;
          state_nxt = S_INS_GRD;
        end else begin
          we = 1'b1; waddr = AW'(i_r); wdata = vi_r;
          state_nxt = S_OUT;
        end
      end
      S_RMX_RD1: begin
        re = 1'b1; raddr = AW'(1);
        state_nxt = S_RMX_RD2;
      end
      S_RMX_RD2: begin
        vtmp_nxt = rdata_r;
        rem_nxt = rdata_r;
        if (cnt_r >= CW'(3)) begin
          re = 1'b1; raddr = AW'(2);
          state_nxt = S_RMX_SEL;
        end else begin
          state_nxt = S_REM_RDL;
        end
      end
      S_RMX_SEL: begin
        if (better) begin
          i_nxt = XW'(2);
          rem_nxt = rdata_r;
        end
        state_nxt = S_REM_RDL;
      end
      S_REM_RDV: begin
        re = 1'b1; raddr = '0;
        state_nxt = S_REM_RDL;
      end
      S_REM_RDL: begin
        if (cmd_r == CMD_REM_MIN || i_r == '0) rem_nxt = rdata_r;
        if (cmd_r == CMD_REM_MAX && i_r != '0) rem_nxt = rem_r;
        re = 1'b1; raddr = AW'(cnt_r - 1'b1);
        cnt_nxt = cnt_r - 1'b1;
        state_nxt = S_REM_PUT;
      end
      S_REM_PUT: begin
        vi_nxt = rdata_r;
        we = 1'b1; waddr = AW'(i_r); wdata = rdata_r;
        mn_nxt = min_level(i_r);
        state_nxt = (XW'(cnt_r) > i_r) ? S_TD_SCAN : S_OUT;
        j_nxt = fc;
        m_nxt = fc;
      end
      S_TD_SCAN: begin
        // j walks first child, second child, then four grandchildren.
        // The walk's pending write of vi at i is deferred; candidate reads of
        // i's own subtree never touch i, so the stale slot is never read.
        if (fc >= XW'(cnt_r)) begin
          we = 1'b1; waddr = AW'(i_r); wdata = vi_r;
          state_nxt = S_OUT;
        end else begin
          re = 1'b1; raddr = AW'(j_r);
          state_nxt = S_TD_CMP;
        end
      end
      S_TD_CMP: begin
        if (rdidx_r == fc || better) begin
          m_nxt = rdidx_r; vm_nxt = rdata_r;
        end
        if (rdidx_r == fc + 1'b1) j_nxt = fg;
        else j_nxt = rdidx_r + 1'b1;
        if ((rdidx_r == fc + 1'b1 || rdidx_r >= fg) &&
            j_nxt < XW'(cnt_r) && j_nxt < fg + XW'(4) && rdidx_r != fc + XW'(1)
            || (rdidx_r == fc && j_nxt < XW'(cnt_r))
            || (rdidx_r == fc + 1'b1 && fg < XW'(cnt_r))) begin
          re = 1'b1; raddr = AW'(j_nxt);
          state_nxt = S_TD_CMP;
        end else begin
          state_nxt = S_TD_SWAP;
        end
      end
      S_TD_SWAP: begin
        if (better) begin
          we = 1'b1; waddr = AW'(i_r); wdata = vm_r;
          if (m_r < fg) begin
            state_nxt = S_TD_RDP;
            vtmp_nxt = vi_r;
            i_nxt = m_r;
            m_nxt = '0;
          end else begin
            i_nxt = m_r;
            m_nxt = XW'(1);
            state_nxt = S_TD_RDP;
          end
        end else begin
          we = 1'b1; waddr = AW'(i_r); wdata = vi_r;
          state_nxt = S_OUT;
        end
      end
      S_TD_RDP: begin
        if (m_r == '0) begin
          // Child swap ends the walk.
          we = 1'b1; waddr = AW'(i_r); wdata = vi_r;
          state_nxt = S_OUT;
        end else begin
          re = 1'b1; raddr = AW'((i_r - 1'b1) >> 1);
          state_nxt = S_TD_PCMP;
        end
      end
      S_TD_PCMP: begin
        if (better) begin
          we = 1'b1; waddr = AW'((i_r - 1'b1) >> 1); wdata = vi_r;
          vi_nxt = rdata_r;
        end
        j_nxt = fc;
        m_nxt = fc;
        state_nxt = S_TD_SCAN;
      end
      S_OUT: begin
        if (!ovalid_r || out_tready) begin
          out_nxt = {6'd0, 8'(cnt_r), rem_r, status_r};
          ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      ovalid_r <= 1'b0;
      rdvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
      rdvalid_r <= re;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt; m_r <= m_nxt; j_r <= j_nxt;
    vi_r <= vi_nxt; vm_r <= vm_nxt; vtmp_r <= vtmp_nxt; mn_r <= mn_nxt;
    status_r <= status_nxt; rem_r <= rem_nxt; cmd_r <= cmd_nxt;
    out_r <= out_nxt;
    if (re) rdidx_r <= XW'(raddr);
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY)) else $error("count above capacity");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("accepted while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS_CMP |-> rdvalid_r) else $error("compare without read");

endmodule
